>>> sv/assert_macros.svh
// assertion macros shared by the renderer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FSR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FSR_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FSR_ASSERT(label, clk, rst_n, prop, msg)

`define FSR_ASSERT_RST(label, clk, prop, msg)

`endif

`endif

>>> sv/fsr_pkg.sv
// types and character constants for the format string renderer
`default_nettype none

package fsr_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_SDEC = 2'd1,
    KIND_UDEC = 2'd2,
    KIND_BIN  = 2'd3
  } kind_t;

  // one classified item waiting for expansion
  typedef struct packed {
    kind_t      kind;
    logic       neg;
    logic [7:0] value;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

`default_nettype wire

>>> sv/format_string_renderer_8bit.sv
// top level of the format string renderer: front end, command queue, back end
//
//   channel  direction  ports                                   handshake
//   in       input      in_fmt_char, in_arg_value               in_valid / in_ready
//   out      output     out_char, out_last_of_run               out_valid / out_ready
//
// one output character per cycle while out_ready holds; the back end sets the rate:
// 1 character per item (plain char, %c, %%, bad specifier), 3 (%u), 4 (%d), 8 (%b).
// items that give no characters (percent, terminator) never reach the queue.
// the front end keeps accepting items while the queue has room (QUEUE_DEPTH entries).
// reset is synchronous, active low; it clears string state, queue and output valid flag.
// a stall on the output holds the current character and lets the queue fill up.
`default_nettype none

module format_string_renderer_8bit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_fmt_char,
  input  wire  [7:0]  in_arg_value,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_char,
  output logic        out_last_of_run
);

  logic              q_full;
  logic              push;
  fsr_pkg::cmd_t     push_cmd;
  logic              pop;
  fsr_pkg::q_head_t  head;

  fsr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_fmt_char  (in_fmt_char),
    .in_arg_value (in_arg_value),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  fsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  fsr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

>>> sv/fsr_front.sv
// front end: takes format characters, tracks string state, classifies each item
`default_nettype none

module fsr_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_fmt_char,
  input  wire  [7:0]        in_arg_value,
  input  wire               q_full,
  output logic              push,
  output fsr_pkg::cmd_t     push_cmd
);

  logic       in_string_r, in_string_nxt;
  logic       after_pct_r, after_pct_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] held_eff;
  logic [7:0] held_neg;
  logic       gen;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign held_eff = in_string_r ? held_r : in_arg_value;
  assign held_neg = 8'd0 - held_eff;
  assign push     = accept && gen;

  always_comb begin
    in_string_nxt  = 1'b1;
    after_pct_nxt  = 1'b0;
    held_nxt       = held_eff;
    gen            = 1'b0;
    push_cmd.kind  = fsr_pkg::KIND_CHAR;
    push_cmd.neg   = 1'b0;
    push_cmd.value = in_fmt_char;
    if (after_pct_r) begin
      gen = 1'b1;
      case (in_fmt_char)
        fsr_pkg::CH_D: begin
          push_cmd.kind = fsr_pkg::KIND_SDEC;
          push_cmd.neg  = held_eff[7];
          // magnitude replaces the held value for the rest of the string
          if (held_eff[7]) begin
            held_nxt = held_neg;
          end
          push_cmd.value = held_nxt;
        end
        fsr_pkg::CH_U: begin
          push_cmd.kind  = fsr_pkg::KIND_UDEC;
          push_cmd.value = held_eff;
        end
        fsr_pkg::CH_B: begin
          push_cmd.kind  = fsr_pkg::KIND_BIN;
          push_cmd.value = held_eff;
        end
        fsr_pkg::CH_C: begin
          push_cmd.value = held_eff;
        end
        fsr_pkg::CH_PERCENT: begin
          push_cmd.value = fsr_pkg::CH_PERCENT;
        end
        fsr_pkg::CH_NUL: begin
          // terminator straight after a percent: flag it and end the string
          push_cmd.value = fsr_pkg::CH_BANG;
          in_string_nxt  = 1'b0;
        end
        default: begin
          push_cmd.value = fsr_pkg::CH_BANG;
        end
      endcase
    end else if (in_fmt_char == fsr_pkg::CH_NUL) begin
      in_string_nxt = 1'b0;
    end else if (in_fmt_char == fsr_pkg::CH_PERCENT) begin
      after_pct_nxt = 1'b1;
    end else begin
      gen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r <= 1'b0;
      after_pct_r <= 1'b0;
      held_r      <= 8'd0;
    end else if (accept) begin
      in_string_r <= in_string_nxt;
      after_pct_r <= after_pct_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/fsr_queue.sv
// short command queue between front and back end
`default_nettype none

`include "assert_macros.svh"

module fsr_queue #(
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  fsr_pkg::cmd_t     push_cmd,
  output logic              full,
  input  wire               pop,
  output fsr_pkg::q_head_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsr_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `FSR_ASSERT(a_no_push_when_full, clk, rst_n, full |-> !push, "push into full queue")
  `FSR_ASSERT(a_no_pop_when_empty, clk, rst_n, pop |-> head.valid, "pop from empty queue")

endmodule

`default_nettype wire

>>> sv/fsr_back.sv
// back end: expands each command into output register characters, one per unstalled cycle
`default_nettype none

`include "assert_macros.svh"

module fsr_back (
  input  wire               clk,
  input  wire               rst_n,
  input  fsr_pkg::q_head_t  head,
  output logic              pop,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [7:0]        out_char,
  output logic              out_last_of_run
);

  logic            busy_r, busy_nxt;
  fsr_pkg::kind_t  kind_r;
  logic            neg_r;
  logic [7:0]      value_r;
  logic [2:0]      step_r;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_char_r;
  logic            out_last_r;

  fsr_pkg::kind_t  cur_kind;
  logic            cur_neg;
  logic [7:0]      cur_val;
  logic [2:0]      cur_step;
  logic [7:0]      ch;
  logic            last;
  logic [7:0]      val_nxt;
  logic [1:0]      hund;
  logic [15:0]     prod;
  logic [3:0]      tens;
  logic            advance;
  logic            emit;

  assign advance = !out_valid_r || out_ready;
  assign emit    = advance && (busy_r || head.valid);
  assign pop     = advance && !busy_r && head.valid;

  // current work: the command in flight, or the queue head when starting fresh
  always_comb begin
    if (busy_r) begin
      cur_kind = kind_r;
      cur_neg  = neg_r;
      cur_val  = value_r;
      cur_step = step_r;
    end else begin
      cur_kind = head.cmd.kind;
      cur_neg  = head.cmd.neg;
      cur_val  = head.cmd.value;
      // unsigned decimal skips the sign position
      cur_step = (head.cmd.kind == fsr_pkg::KIND_UDEC) ? 3'd1 : 3'd0;
    end
  end

  assign hund = (cur_val >= 8'd200) ? 2'd2 : ((cur_val >= 8'd100) ? 2'd1 : 2'd0);
  // remainder below 100 here, so x*205>>11 equals x/10
  assign prod = {8'd0, cur_val} * 16'd205;
  assign tens = prod[14:11];

  always_comb begin
    ch      = cur_val;
    last    = 1'b1;
    val_nxt = cur_val;
    case (cur_kind)
      fsr_pkg::KIND_CHAR: begin
        ch   = cur_val;
        last = 1'b1;
      end
      fsr_pkg::KIND_SDEC, fsr_pkg::KIND_UDEC: begin
        case (cur_step)
          3'd0: begin
            ch   = cur_neg ? fsr_pkg::CH_MINUS : fsr_pkg::CH_SPACE;
            last = 1'b0;
          end
          3'd1: begin
            ch   = fsr_pkg::CH_ZERO + {6'd0, hund};
            last = 1'b0;
            case (hund)
              2'd2:    val_nxt = cur_val - 8'd200;
              2'd1:    val_nxt = cur_val - 8'd100;
              default: val_nxt = cur_val;
            endcase
          end
          3'd2: begin
            ch      = fsr_pkg::CH_ZERO + {4'd0, tens};
            last    = 1'b0;
            val_nxt = cur_val - 8'({4'd0, tens} * 8'd10);
          end
          default: begin
            ch   = fsr_pkg::CH_ZERO + {4'd0, cur_val[3:0]};
            last = 1'b1;
          end
        endcase
      end
      fsr_pkg::KIND_BIN: begin
        ch      = cur_val[7] ? fsr_pkg::CH_ONE : fsr_pkg::CH_ZERO;
        last    = (cur_step == 3'd7);
        val_nxt = {cur_val[6:0], 1'b0};
      end
      default: begin
        ch   = cur_val;
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      busy_nxt      = !last;
      out_valid_nxt = 1'b1;
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r     <= cur_kind;
      neg_r      <= cur_neg;
      value_r    <= val_nxt;
      step_r     <= cur_step + 3'd1;
      out_char_r <= ch;
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;

  `FSR_ASSERT(a_busy_has_output, clk, rst_n, busy_r |-> out_valid_r, "command in flight without pending output")
  `FSR_ASSERT(a_char_never_busy, clk, rst_n, busy_r |-> (kind_r != fsr_pkg::KIND_CHAR), "single character left work behind")
  `FSR_ASSERT(a_stall_holds_char, clk, rst_n, (out_valid_r && !out_ready) |=> $stable(out_char_r), "output character changed while stalled")
  `FSR_ASSERT_RST(a_reset_clears, clk, !rst_n |=> (!busy_r && !out_valid_r), "reset left back end active")

endmodule

`default_nettype wire
